[sv/scs_pkg.sv]
// Shared constants, operation codes and controller/datapath interface types.
package scs_pkg;

  localparam int TERMS_DEF = 20;
  localparam int N_W       = 8;   // series index n, up to 2*TERMS-2
  localparam int FRAC      = 40;  // internal fraction bits

  localparam logic signed [31:0] TWO_PI_Q24 = 32'sd105414357;
  localparam logic signed [31:0] SMALL_Q24  = 32'sd1677722;
  localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;

  typedef logic [2:0] mul_op_t;
  localparam mul_op_t OP_X2  = 3'd0;  // x*x            -> x2
  localparam mul_op_t OP_TS  = 3'd1;  // sine term*x2   -> tmp
  localparam mul_op_t OP_TSR = 3'd2;  // tmp*recip even -> -sine term
  localparam mul_op_t OP_TC  = 3'd3;  // cos term*x2    -> tmp
  localparam mul_op_t OP_TCR = 3'd4;  // tmp*recip odd  -> -cos term

  typedef struct packed {
    logic           load;
    logic           reduce;
    logic           series_init;
    logic           small_out;
    logic           mul_en;
    mul_op_t        mul_op;
    logic [2:0]     mul_ph;
    logic           div_en;
    logic           div_odd;
    logic [3:0]     div_ph;
    logic [N_W-1:0] div_n;
    logic           term_add;
    logic           fin_a;
    logic           fin_b;
  } scs_cmd_t;

  typedef struct packed {
    logic in_range;
    logic near_zero;
  } scs_sts_t;

endpackage

[sv/scs_ctrl.sv]
// Sequencer: range reduction loop, term loop, multiply and divide phasing.
module scs_ctrl #(
  parameter int TERMS = scs_pkg::TERMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  scs_pkg::scs_sts_t sts,
  output scs_pkg::scs_cmd_t cmd
);

  localparam int KW = $clog2(TERMS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_X2   = 4'd3;
  localparam logic [3:0] S_TADD = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_MTS  = 4'd7;
  localparam logic [3:0] S_MTSR = 4'd8;
  localparam logic [3:0] S_MTC  = 4'd9;
  localparam logic [3:0] S_MTCR = 4'd10;
  localparam logic [3:0] S_FINA = 4'd11;
  localparam logic [3:0] S_FINB = 4'd12;

  localparam logic [3:0] MUL_LAST = 4'd7;
  localparam logic [3:0] DIV_LAST = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [KW-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    cmd        = '0;
    cmd.mul_ph = cnt_r[2:0];
    cmd.div_ph = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        if (sts.in_range) state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        k_nxt   = '0;
        if (sts.near_zero) begin
          cmd.small_out = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.series_init = 1'b1;
          state_nxt       = S_X2;
        end
      end
      S_X2, S_MTS, S_MTSR, S_MTC, S_MTCR: begin
        cmd.mul_en = 1'b1;
        unique case (state_r)
          S_X2:    cmd.mul_op = scs_pkg::OP_X2;
          S_MTS:   cmd.mul_op = scs_pkg::OP_TS;
          S_MTSR:  cmd.mul_op = scs_pkg::OP_TSR;
          S_MTC:   cmd.mul_op = scs_pkg::OP_TC;
          default: cmd.mul_op = scs_pkg::OP_TCR;
        endcase
        if (cnt_r == MUL_LAST) begin
          cnt_nxt = '0;
          unique case (state_r)
            S_X2:   state_nxt = S_TADD;
            S_MTS:  state_nxt = S_MTSR;
            S_MTSR: state_nxt = S_MTC;
            S_MTC:  state_nxt = S_MTCR;
            default: begin
              k_nxt     = k_r + KW'(1);
              state_nxt = S_TADD;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_TADD: begin
        cmd.term_add = 1'b1;
        cnt_nxt      = '0;
        if (k_r == KW'(TERMS - 1)) state_nxt = S_FINA;
        else                       state_nxt = S_DIV1;
      end
      S_DIV1, S_DIV2: begin
        cmd.div_en  = 1'b1;
        cmd.div_odd = (state_r == S_DIV1);
        if (state_r == S_DIV1) cmd.div_n = scs_pkg::N_W'({k_r, 1'b1});
        else cmd.div_n = scs_pkg::N_W'({k_r, 1'b0}) + scs_pkg::N_W'(2);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_DIV1) ? S_DIV2 : S_MTS;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_FINA: begin
        cmd.fin_a = 1'b1;
        state_nxt = S_FINB;
      end
      S_FINB: begin
        cmd.fin_b = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/scs_datapath.sv]
// Datapath: angle reduction, shared 32x32 multiplier, reciprocal divider, sums, output rounding.
module scs_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [31:0]       in_angle,
  input  scs_pkg::scs_cmd_t        cmd,
  output scs_pkg::scs_sts_t        sts,
  output logic                     out_valid,
  output logic signed [31:0]       out_sine,
  output logic signed [31:0]       out_cosine
);

  localparam int ACC_W = 2 * scs_pkg::FRAC + 23;  // bits up to the top of the Q40 magnitude

  logic signed [31:0] x_r;
  logic signed [63:0] x2_r, ts_r, tc_r, tmp_r, ss_r, sc_r;
  logic [63:0]        ua_r, ub_r, pp_r;
  logic               neg_r;
  logic [1:0]         pp_sel_r;
  logic [ACC_W-1:0]   acc_r;
  logic [62:0]        mag_r;
  logic [15:0]        d_r, rem_r;
  logic [47:0]        num_r, quo_r;
  logic [39:0]        r_odd_r, r_even_r;
  logic [53:0]        ms_r, mc_r;
  logic               sneg_r, cneg_r;
  logic               out_valid_r;
  logic signed [31:0] out_sine_r, out_cosine_r;

  logic signed [63:0] xq, op_a, op_b, res, wb;
  logic [31:0]        fa, fb;
  logic [ACC_W-1:0]   pp_sh, rnd;
  logic [15:0]        rem_nxt;
  logic [7:0]         qbyte;
  logic [30:0]        sat_s, sat_c;

  assign xq = {{16{x_r[31]}}, x_r, 16'b0};

  assign sts.in_range  = !(x_r > scs_pkg::TWO_PI_Q24) && !(x_r < -scs_pkg::TWO_PI_Q24);
  assign sts.near_zero = (x_r > -scs_pkg::SMALL_Q24) && (x_r < scs_pkg::SMALL_Q24);

  always_comb begin
    unique case (cmd.mul_op)
      scs_pkg::OP_X2:  begin op_a = xq;    op_b = xq;   end
      scs_pkg::OP_TS:  begin op_a = ts_r;  op_b = x2_r; end
      scs_pkg::OP_TSR: begin op_a = tmp_r; op_b = {24'b0, r_even_r}; end
      scs_pkg::OP_TC:  begin op_a = tc_r;  op_b = x2_r; end
      default:         begin op_a = tmp_r; op_b = {24'b0, r_odd_r}; end
    endcase
  end

  // partial product select: ll, lh, hl, hh
  always_comb begin
    unique case (cmd.mul_ph[1:0] - 2'd1)
      2'd0:    begin fa = ua_r[31:0];  fb = ub_r[31:0];  end
      2'd1:    begin fa = ua_r[31:0];  fb = ub_r[63:32]; end
      2'd2:    begin fa = ua_r[63:32]; fb = ub_r[31:0];  end
      default: begin fa = ua_r[63:32]; fb = ub_r[63:32]; end
    endcase
  end

  always_comb begin
    unique case (pp_sel_r)
      2'd0:    pp_sh = ACC_W'(pp_r);
      2'd1:    pp_sh = ACC_W'(pp_r) << 32;
      2'd2:    pp_sh = ACC_W'(pp_r) << 32;
      default: pp_sh = ACC_W'(pp_r) << 64;
    endcase
  end

  assign rnd = acc_r + (ACC_W'(1) << (scs_pkg::FRAC - 1));
  assign res = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign wb  = (cmd.mul_op == scs_pkg::OP_TSR || cmd.mul_op == scs_pkg::OP_TCR) ? -res : res;

  // eight quotient bits per cycle, restoring
  always_comb begin
    logic [16:0] r;
    r     = {1'b0, rem_r};
    qbyte = '0;
    for (int i = 0; i < 8; i++) begin
      r = {r[15:0], num_r[47-i]};
      if (r >= {1'b0, d_r}) begin
        r            = r - {1'b0, d_r};
        qbyte[7-i]   = 1'b1;
      end
    end
    rem_nxt = r[15:0];
  end

  assign sat_s = (ms_r > 54'(scs_pkg::ONE_Q30)) ? 31'(scs_pkg::ONE_Q30) : ms_r[30:0];
  assign sat_c = (mc_r > 54'(scs_pkg::ONE_Q30)) ? 31'(scs_pkg::ONE_Q30) : mc_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.small_out | cmd.fin_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= in_angle;
    if (cmd.reduce) begin
      if (x_r > scs_pkg::TWO_PI_Q24)       x_r <= x_r - scs_pkg::TWO_PI_Q24;
      else if (x_r < -scs_pkg::TWO_PI_Q24) x_r <= x_r + scs_pkg::TWO_PI_Q24;
    end
    if (cmd.series_init) begin
      ss_r <= '0;
      sc_r <= '0;
      ts_r <= xq;
      tc_r <= 64'sd1 <<< scs_pkg::FRAC;
    end
    if (cmd.term_add) begin
      ss_r <= ss_r + ts_r;
      sc_r <= sc_r + tc_r;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_ph)
        3'd0: begin
          ua_r  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
          ub_r  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
          neg_r <= op_a[63] ^ op_b[63];
          acc_r <= '0;
        end
        3'd1: begin
          pp_r     <= 64'(fa) * 64'(fb);
          pp_sel_r <= cmd.mul_ph[1:0] - 2'd1;
        end
        3'd2, 3'd3, 3'd4: begin
          pp_r     <= 64'(fa) * 64'(fb);
          pp_sel_r <= cmd.mul_ph[1:0] - 2'd1;
          acc_r    <= acc_r + pp_sh;
        end
        3'd5: acc_r <= acc_r + pp_sh;
        3'd6: mag_r <= rnd[ACC_W-1:scs_pkg::FRAC];
        default: begin
          unique case (cmd.mul_op)
            scs_pkg::OP_X2:  x2_r  <= wb;
            scs_pkg::OP_TSR: ts_r  <= wb;
            scs_pkg::OP_TCR: tc_r  <= wb;
            default:         tmp_r <= wb;
          endcase
        end
      endcase
    end
    if (cmd.div_en) begin
      unique case (cmd.div_ph)
        4'd0: d_r <= 16'(cmd.div_n) * (16'(cmd.div_n) + 16'd1);
        4'd1: begin
          num_r <= (48'd1 << scs_pkg::FRAC) + 48'(d_r >> 1);
          rem_r <= '0;
          quo_r <= '0;
        end
        4'd8: begin
          if (cmd.div_odd) r_odd_r  <= quo_r[39:0];
          else             r_even_r <= quo_r[39:0];
        end
        default: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[39:0], qbyte};
          num_r <= {num_r[39:0], 8'b0};
        end
      endcase
    end
    if (cmd.fin_a) begin
      sneg_r <= ss_r[63];
      cneg_r <= sc_r[63];
      ms_r   <= 54'((ss_r[63] ? (~ss_r + 64'sd513) : (ss_r + 64'sd512)) >>> 10);
      mc_r   <= 54'((sc_r[63] ? (~sc_r + 64'sd513) : (sc_r + 64'sd512)) >>> 10);
    end
    if (cmd.fin_b) begin
      out_sine_r   <= sneg_r ? -$signed({1'b0, sat_s}) : $signed({1'b0, sat_s});
      out_cosine_r <= cneg_r ? -$signed({1'b0, sat_c}) : $signed({1'b0, sat_c});
    end
    if (cmd.small_out) begin
      out_sine_r   <= x_r <<< 6;
      out_cosine_r <= scs_pkg::ONE_Q30;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;

endmodule

[sv/sine_cosine_series.sv]
// Top level: sine and cosine of a Q8.24 angle by alternating Taylor sums.
// A reduced angle below 0.1 skips the series; reduction takes R = 0..20 steps of 2*pi.
// Otherwise TERMS terms are summed; each further term costs two reciprocal divisions
// and four passes through the one 32x32 multiplier.
// Throughput: one item at a time; start is taken again in the cycle the result shows.
// Reset: synchronous active-low rst_n returns the sequencer to idle and clears out_valid.
// The receiver cannot stall: out_valid is a one-cycle strobe per transfer.
module sine_cosine_series #(
  parameter int TERMS = scs_pkg::TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_sine,
  output logic signed [31:0] out_cosine
);

  scs_pkg::scs_cmd_t cmd;
  scs_pkg::scs_sts_t sts;

  // sequencer: reduction loop, term loop, multiply/divide phase counts
  scs_ctrl #(.TERMS(TERMS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // all arithmetic and the result register
  scs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_angle   (in_angle),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

endmodule

[sv/scs_checker.sv]
// Port-level checks for the sine/cosine block, bound to the top level.
module scs_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_sine,
  input logic signed [31:0] out_cosine
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transfer did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("work ended without a result");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results in a row");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine <= 32'sd1073741824) && (out_sine >= -32'sd1073741824) &&
                  (out_cosine <= 32'sd1073741824) && (out_cosine >= -32'sd1073741824))
    else $error("result outside +-1");

endmodule

bind sine_cosine_series scs_port_checks u_scs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_sine   (out_sine),
  .out_cosine (out_cosine)
);
